// File: hw/rtl/stbs_pkg.sv
`default_nettype none

package stbs_pkg;

  // Default table depth and the fixed field widths
  localparam int DEPTH_DEF = 256;
  localparam int CNT_W     = 9;
  localparam int IDX_W     = 8;
  localparam int WORD_W    = 32;

  // Request kinds
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [IDX_W-1:0]  index;
    logic [WORD_W-1:0] value;
  } in_req_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] rank;
  } out_req_t;

  // Outcome of the shared key/probe compare
  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_t;

endpackage

`default_nettype wire

// File: hw/rtl/sorted_table_binary_search_top.sv
`default_nettype none

// Channel   Ports                         Direction  Moves
// --------  ----------------------------  ---------  ---------------------------------
// input     in_valid, in_stall, in_data   in         request: write entry or search key
// result    out_valid, out_stall, out_data out       found flag and rank, one per search
// config    cfg_we, cfg_wdata             in         entry_count, 9 bits
//
// A write request is taken in the idle state. A search passes through an
// accept, the low and then the high bound check and then the probes, at most
// about log2(entry_count) of them, then a hand-over. The probes run one after
// another through the shared compare and the single RAM read port. The block
// holds in_stall high from accept until the result moves into the output
// register. Synchronous reset clears the sequencer, the output valid and
// entry_count; the table is not cleared.

module sorted_table_binary_search_top #(
  parameter int DEPTH = stbs_pkg::DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire stbs_pkg::in_req_t          in_data,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output stbs_pkg::out_req_t              out_data,
  input  wire logic                       cfg_we,
  input  wire logic [stbs_pkg::CNT_W-1:0] cfg_wdata
);

  import stbs_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic [CNT_W-1:0]  cfg_count_r;
  logic              out_valid_r;
  out_req_t          out_data_r;

  logic              idle;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_rdata;
  logic              res_valid;
  logic              res_take;
  out_req_t          res_data;

  // Configuration register: written directly, no read-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_count_r <= '0;
    end else if (cfg_we) begin
      cfg_count_r <= cfg_wdata;
    end
  end

  // Hold off new requests while a search is in flight
  assign in_stall = !idle;

  stbs_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  stbs_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_data     (in_data),
    .idle        (idle),
    .entry_count (cfg_count_r),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .res_valid   (res_valid),
    .res_take    (res_take),
    .res_data    (res_data)
  );

  // Advance a finished result once the output register is free or draining
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// File: hw/rtl/stbs_ram.sv
`default_nettype none

module stbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hw/rtl/stbs_cmp.sv
`default_nettype none

module stbs_cmp (
  input  wire logic [stbs_pkg::WORD_W-1:0] key,
  input  wire logic [stbs_pkg::WORD_W-1:0] probe,
  output stbs_pkg::cmp_t                   res
);

  import stbs_pkg::*;

  // Unsigned magnitude compare of key against the word read back
  assign res.lt = (key < probe);
  assign res.eq = (key == probe);

endmodule

`default_nettype wire

// File: hw/rtl/stbs_ctrl.sv
`default_nettype none

module stbs_ctrl #(
  parameter int DEPTH = stbs_pkg::DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire stbs_pkg::in_req_t           in_data,
  output logic                             idle,
  input  wire logic [stbs_pkg::CNT_W-1:0]  entry_count,
  output logic                             ram_we,
  output logic [$clog2(DEPTH)-1:0]         ram_waddr,
  output logic [stbs_pkg::WORD_W-1:0]      ram_wdata,
  output logic [$clog2(DEPTH)-1:0]         ram_raddr,
  input  wire logic [stbs_pkg::WORD_W-1:0] ram_rdata,
  output logic                             res_valid,
  input  wire logic                        res_take,
  output stbs_pkg::out_req_t               res_data
);

  import stbs_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam logic [31:0] DEPTH_W = 32'(DEPTH);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_LO   = 5'b00010,
    ST_HI   = 5'b00100,
    ST_MID  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [WORD_W-1:0] key_r, key_nxt;
  logic [AW-1:0]     lo_r, lo_nxt;
  logic [AW-1:0]     hi_r, hi_nxt;
  logic [AW-1:0]     mid_r, mid_nxt;
  logic [AW-1:0]     pos_r, pos_nxt;
  logic              eq_lo_r, eq_lo_nxt;
  logic              eq_hi_r, eq_hi_nxt;
  logic              found_r, found_nxt;

  logic [AW:0]       sum_cur;
  logic [AW:0]       sum_new;
  logic [AW-1:0]     hi_init;
  logic              tbl_empty;
  logic              wr_in_range;
  cmp_t              cmp;

  stbs_cmp u_cmp (
    .key   (key_r),
    .probe (ram_rdata),
    .res   (cmp)
  );

  // Last valid position: count clamped to the depth, less one
  assign tbl_empty   = (entry_count == '0);
  assign hi_init     = ({23'd0, entry_count} >= DEPTH_W) ? AW'(DEPTH - 1)
                                                         : AW'(entry_count - 9'd1);
  assign wr_in_range = ({24'd0, in_data.index} < DEPTH_W);

  assign sum_cur = {1'b0, lo_r} + {1'b0, hi_r};

  assign ram_waddr = AW'(in_data.index);
  assign ram_wdata = in_data.value;

  assign idle          = (state_r == ST_IDLE);
  assign res_data.found = found_r;
  assign res_data.rank  = found_r ? 8'(pos_r) : '0;

  always_comb begin
    state_nxt    = state_r;
    key_nxt      = key_r;
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    mid_nxt      = mid_r;
    pos_nxt      = pos_r;
    eq_lo_nxt    = eq_lo_r;
    eq_hi_nxt    = eq_hi_r;
    found_nxt    = found_r;
    sum_new      = sum_cur;
    ram_raddr    = '0;
    ram_we       = 1'b0;
    res_valid    = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        // Entry zero is read on the accept edge
        ram_raddr = '0;
        if (in_valid) begin
          if (in_data.kind == KIND_WRITE) begin
            ram_we = wr_in_range;
          end else begin
            key_nxt   = in_data.value;
            lo_nxt    = '0;
            hi_nxt    = hi_init;
            eq_lo_nxt = 1'b0;
            eq_hi_nxt = 1'b0;
            if (tbl_empty) begin
              found_nxt = 1'b0;
              pos_nxt   = '0;
              state_nxt = ST_DONE;
            end else begin
              state_nxt = ST_LO;
            end
          end
        end
      end

      ST_LO: begin
        // Check the low bound, fetch the high one
        ram_raddr = hi_r;
        if (cmp.lt) begin
          found_nxt = 1'b0;
          pos_nxt   = '0;
          state_nxt = ST_DONE;
        end else begin
          eq_lo_nxt = cmp.eq;
          state_nxt = ST_HI;
        end
      end

      ST_HI: begin
        ram_raddr = sum_cur[AW:1];
        if (!cmp.lt && !cmp.eq) begin
          found_nxt = 1'b0;
          pos_nxt   = '0;
          state_nxt = ST_DONE;
        end else begin
          eq_hi_nxt = cmp.eq;
          if ((hi_r - lo_r) > AW'(1)) begin
            mid_nxt   = sum_cur[AW:1];
            state_nxt = ST_MID;
          end else begin
            found_nxt = eq_lo_r | cmp.eq;
            pos_nxt   = eq_lo_r ? lo_r : hi_r;
            state_nxt = ST_DONE;
          end
        end
      end

      ST_MID: begin
        if (cmp.eq) begin
          found_nxt = 1'b1;
          pos_nxt   = mid_r;
          state_nxt = ST_DONE;
        end else begin
          // A moved bound came from an unequal probe: drop its match flag
          if (cmp.lt) begin
            hi_nxt    = mid_r;
            eq_hi_nxt = 1'b0;
          end else begin
            lo_nxt    = mid_r;
            eq_lo_nxt = 1'b0;
          end
          sum_new   = {1'b0, lo_nxt} + {1'b0, hi_nxt};
          ram_raddr = sum_new[AW:1];
          if ((hi_nxt - lo_nxt) > AW'(1)) begin
            mid_nxt = sum_new[AW:1];
          end else begin
            found_nxt = eq_lo_nxt | eq_hi_nxt;
            pos_nxt   = eq_lo_nxt ? lo_nxt : hi_nxt;
            state_nxt = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    mid_r   <= mid_nxt;
    pos_r   <= pos_nxt;
    eq_lo_r <= eq_lo_nxt;
    eq_hi_r <= eq_hi_nxt;
    found_r <= found_nxt;
  end

endmodule

`default_nettype wire

// File: dv/stbs_lookup_check.sv
`timescale 1ns / 100ps

module stbs_lookup_check
  import stbs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  in_req_t           in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  out_req_t          out_data,
  input  logic              cfg_we,
  input  logic [CNT_W-1:0]  cfg_wdata,
  output int                fail_count,
  output int                outstanding
);

  typedef struct packed {
    logic [WORD_W-1:0] key;
    out_req_t          want;
  } lookup_t;

  logic [WORD_W-1:0] words [DEPTH_DEF];
  logic [CNT_W-1:0]  live_count;
  lookup_t           awaited_ranks [$];
  int                errors = 0;

  // Search the local copy of the table the way the block does
  function automatic out_req_t predict_rank(input logic [WORD_W-1:0] key);
    int unsigned n;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    out_req_t    r;
    r  = '0;
    n  = (live_count > DEPTH_DEF) ? DEPTH_DEF : live_count;
    if (n == 0) return r;
    lo = 0;
    hi = n - 1;
    if (words[lo] > key || words[hi] < key) return r;
    while (hi - lo > 1) begin
      mid = (lo + hi) >> 1;
      if (key == words[mid]) begin
        r.found = 1'b1;
        r.rank  = IDX_W'(mid);
        return r;
      end
      if (key < words[mid]) hi = mid;
      else                  lo = mid;
    end
    if (key == words[lo]) begin
      r.found = 1'b1;
      r.rank  = IDX_W'(lo);
    end else if (key == words[hi]) begin
      r.found = 1'b1;
      r.rank  = IDX_W'(hi);
    end
    return r;
  endfunction

  always @(posedge clk) begin : track
    lookup_t head;
    if (!rst_n) begin
      awaited_ranks.delete();
      live_count = '0;
    end else begin
      if (cfg_we) live_count = cfg_wdata;
      if (in_valid && !in_stall) begin
        if (in_data.kind == KIND_WRITE) begin
          words[in_data.index] = in_data.value;
        end else begin
          head.key  = in_data.value;
          head.want = predict_rank(in_data.value);
          awaited_ranks.push_back(head);
        end
      end
      if (out_valid && !out_stall) begin
        if (awaited_ranks.size() == 0) begin
          errors++;
          $display("%0t: result found=%0b rank=%0d with no search waiting",
                   $time, out_data.found, out_data.rank);
        end else begin
          head = awaited_ranks.pop_front();
          if (out_data.found !== head.want.found || out_data.rank !== head.want.rank) begin
            errors++;
            $display("%0t: key %h expected found=%0b rank=%0d, got found=%0b rank=%0d",
                     $time, head.key, head.want.found, head.want.rank,
                     out_data.found, out_data.rank);
          end
        end
      end
    end
    fail_count  <= errors;
    outstanding <= awaited_ranks.size();
  end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import stbs_pkg::*;

  localparam int ITEM_TARGET   = 1350;
  localparam int SETTLE_CYCLES = 20;    // covers a search in flight plus hand-over
  localparam int LONG_HOLD     = 300;   // result side back-pressure stretch
  localparam int STALL_LIMIT   = 2000;  // cycles with no transfer at all

  typedef enum {FILL_SPAN, FILL_DENSE, FILL_SPARSE, FILL_NOISE} fill_mode_e;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  in_req_t            in_data;
  logic               out_valid;
  logic               out_stall;
  out_req_t           out_data;
  logic               cfg_we;
  logic [CNT_W-1:0]   cfg_wdata;

  int                 fail_count;
  int                 outstanding;
  int                 idle_cycles = 0;

  // Stimulus-side view of the table, used only to aim search keys
  logic [WORD_W-1:0]  tbl_shadow [DEPTH_DEF];
  int unsigned        sent_items = 0;
  bit                 src_quiet = 1'b0;
  bit                 sink_quiet = 1'b0;
  bit                 hold_off_req = 1'b0;

  always #5 clk = ~clk;

  sorted_table_binary_search_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  stbs_lookup_check i_lookup_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Offer one request after a random gap and hold it until the block takes it.
  // Valid stays high across back-to-back requests, so it is only lowered for a gap.
  task automatic send_req(input logic kind, input logic [IDX_W-1:0] idx,
                          input logic [WORD_W-1:0] val);
    in_req_t     req;
    int unsigned gap;
    req.kind  = kind;
    req.index = idx;
    req.value = val;
    gap = src_quiet ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= req;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (kind == KIND_WRITE) tbl_shadow[idx] = val;
    sent_items++;
  endtask

  task automatic look_up(input logic [WORD_W-1:0] key);
    send_req(KIND_SEARCH, IDX_W'($urandom), key);
  endtask

  // Drop valid, wait for every search to answer, then let any trailing write retire
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The count register may only change while the block is idle
  task automatic set_count(input int unsigned n);
    settle();
    cfg_wdata <= CNT_W'(n);
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Rewrite entries 0..n-1: ascending across the full word range, ascending with
  // duplicates, ascending with sparse gaps, or plain noise that breaks the order
  task automatic load_table(input int unsigned n, input fill_mode_e mode);
    logic [63:0]       acc;
    logic [WORD_W-1:0] word;
    acc = (mode == FILL_SPAN) ? 64'd0 : 64'($urandom_range(0, 32'h00FF_FFFF));
    for (int unsigned i = 0; i < n; i++) begin
      case (mode)
        FILL_SPAN: begin
          if (i != 0) acc += $urandom_range(0, 1 << 25);
        end
        FILL_DENSE:  acc += $urandom_range(0, 2);
        FILL_SPARSE: acc += $urandom_range(1, 1 << 20);
        default:     acc = 64'($urandom);
      endcase
      word = (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[WORD_W-1:0];
      if (mode == FILL_SPAN && i == n - 1) word = 32'hFFFF_FFFF;
      send_req(KIND_WRITE, IDX_W'(i), word);
    end
  endtask

  // Aim mostly at stored words, their neighbours and the bounds of the live range
  function automatic logic [WORD_W-1:0] pick_key(input int unsigned n);
    int unsigned i;
    if (n == 0) return $urandom;
    i = $urandom_range(0, n - 1);
    case ($urandom_range(0, 10))
      0, 1, 2, 3, 4: return tbl_shadow[i];
      5:             return tbl_shadow[i] + 32'd1;
      6:             return tbl_shadow[i] - 32'd1;
      7:             return tbl_shadow[0] - 32'd1;
      8:             return tbl_shadow[n-1] + 32'd1;
      9:             return $urandom;
      default:       return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
    endcase
  endfunction

  // Result side: stall for a random number of cycles before each result,
  // or for one long stretch when asked, so the block backs up into its input
  initial begin : result_sink
    int unsigned hold;
    out_stall <= 1'b1;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold         = LONG_HOLD;
        hold_off_req = 1'b0;
      end else begin
        hold = sink_quiet ? 0 : $urandom_range(0, 7);
      end
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Abort if nothing moves on any channel for too long
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned       n;
    int unsigned       eff;
    int unsigned       phase;
    int unsigned       i;
    logic [WORD_W-1:0] lo;
    logic [WORD_W-1:0] hi;
    logic [WORD_W-1:0] word;
    fill_mode_e        mode;

    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table straight out of reset: every search misses without a probe
    send_req(KIND_SEARCH, 8'h00, 32'h0000_0000);
    send_req(KIND_SEARCH, 8'hFF, 32'hFFFF_FFFF);

    // Fill the whole table so no later search can touch an unwritten entry
    load_table(DEPTH_DEF, FILL_SPAN);

    // Full table: both extremes, the middle, near the ends and a key in a gap
    set_count(DEPTH_DEF);
    look_up(32'h0000_0000);
    look_up(32'hFFFF_FFFF);
    look_up(tbl_shadow[128]);
    look_up(tbl_shadow[1]);
    look_up(tbl_shadow[254]);
    look_up(tbl_shadow[37] + 32'd1);

    // Single entry: hit, then a key above the only entry
    set_count(1);
    look_up(tbl_shadow[0]);
    look_up(tbl_shadow[0] + 32'd1);

    // Two entries: the search loop never runs, only the final checks
    set_count(2);
    look_up(tbl_shadow[1]);
    look_up(tbl_shadow[1] - 32'd1);
    look_up(tbl_shadow[1] + 32'd1);

    // Count above the depth clamps to the depth
    set_count(511);
    look_up(32'hFFFF_FFFF);
    look_up(tbl_shadow[200]);

    // Break the order inside the live range; the answer follows the probes
    set_count(11);
    send_req(KIND_WRITE, 8'd5, 32'hFFFF_FFFF);
    look_up(tbl_shadow[7]);
    look_up(tbl_shadow[3]);
    look_up(32'hFFFF_FFFF);

    // Random phases: new count, often a fresh table, then a burst of requests
    phase = 0;
    while (sent_items < ITEM_TARGET) begin
      case ($urandom_range(0, 19))
        0:                   n = 0;
        1:                   n = DEPTH_DEF;
        2:                   n = $urandom_range(DEPTH_DEF + 1, 511);
        3, 4, 5, 6, 7, 8, 9: n = $urandom_range(1, 8);
        10, 11, 12, 13, 14, 15: n = $urandom_range(9, 64);
        default:             n = $urandom_range(65, DEPTH_DEF - 1);
      endcase
      eff = (n > DEPTH_DEF) ? DEPTH_DEF : n;
      if (eff != 0 && $urandom_range(0, 1) == 1) begin
        case ($urandom_range(0, 7))
          0:       mode = FILL_NOISE;
          1, 2:    mode = FILL_DENSE;
          3, 4, 5: mode = FILL_SPAN;
          default: mode = FILL_SPARSE;
        endcase
        load_table(eff, mode);
      end
      set_count(n);

      src_quiet  = ($urandom_range(0, 3) == 0);
      sink_quiet = ($urandom_range(0, 3) == 0);
      // Once, starve the result side while requests keep coming
      if (phase == 2) begin
        src_quiet    = 1'b1;
        hold_off_req = 1'b1;
      end

      repeat ($urandom_range(15, 40)) begin
        if ($urandom_range(0, 7) == 0) begin
          // Overwrite one entry, mostly keeping it between its neighbours
          i  = $urandom_range(0, DEPTH_DEF - 1);
          lo = (i == 0) ? 32'h0 : tbl_shadow[i-1];
          hi = (i == DEPTH_DEF - 1) ? 32'hFFFF_FFFF : tbl_shadow[i+1];
          if (lo <= hi && $urandom_range(0, 3) != 0)
            word = lo + WORD_W'({32'b0, $urandom} % ({32'b0, hi - lo} + 64'd1));
          else
            word = $urandom;
          send_req(KIND_WRITE, IDX_W'(i), word);
        end else begin
          look_up(pick_key(eff));
        end
      end
      phase++;
    end

    // Drain and give the verdict
    src_quiet  = 1'b0;
    sink_quiet = 1'b0;
    settle();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: sorted_table_binary_search_top.f
hw/rtl/stbs_pkg.sv
hw/rtl/stbs_ram.sv
hw/rtl/stbs_cmp.sv
hw/rtl/stbs_ctrl.sv
hw/rtl/sorted_table_binary_search_top.sv
dv/stbs_lookup_check.sv
dv/testbench.sv
